[design/msr_pkg.sv]
// package: types, constants and fixed-point helpers for the rope step unit
package msr_pkg;

  localparam int MAX_NODES = 64;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] DAMP_EULER = (64'sd5 * ONE + 64'sd500) / 64'sd1000;
  localparam logic signed [63:0] DAMP_VERLET = (64'sd5 * ONE + 64'sd50000) / 64'sd100000;
  localparam logic signed [63:0] KEEP_VERLET = ONE - DAMP_VERLET;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic {
    OP_LOAD,
    OP_STEP
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_COUNT,
    CFG_TSTEP,
    CFG_GRAV_X,
    CFG_GRAV_Y,
    CFG_STIFF,
    CFG_MASS,
    CFG_REST
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    SP_RD_A,
    SP_LD_A,
    SP_RD_B,
    SP_LD_B,
    SP_GEO,
    SP_SQ,
    SP_ROOT,
    SP_EXT,
    SP_M,
    SP_D,
    SP_K,
    SP_APPLY,
    SP_WR,
    SP_WR_LAST,
    ND_RD,
    ND_LD,
    ND_DAMP,
    ND_ACC,
    ND_VEL,
    ND_POS,
    ND_H,
    ND_G,
    ND_E,
    ND_VUP,
    ND_WR,
    ND_NEXT,
    OT_RD,
    OT_EM
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [5:0]         node_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               pinned;
  } cmd_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               last_node;
  } result_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               pin;
  } node_t;

  typedef struct packed {
    alu_op_t            op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] res;
  } alu_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) return 32'sh7fffffff;
    if (v < S32_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sdiv_one(input logic signed [63:0] v);
    logic signed [63:0] adj;
    adj = v[63] ? (ONE - 64'sd1) : 64'sd0;
    return (v + adj) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] half(input logic signed [63:0] v);
    logic signed [63:0] adj;
    adj = v[63] ? 64'sd1 : 64'sd0;
    return (v + adj) >>> 1;
  endfunction

  function automatic node_t mask_node(input node_t n, input logic v);
    node_t m;
    m = n;
    if (!v) begin
      m.vx = '0;
      m.vy = '0;
      m.fx = '0;
      m.fy = '0;
      m.pin = 1'b0;
    end
    return m;
  endfunction

endpackage

[design/mass_spring_rope_step_unit.sv]
// top level: rope of spring-joined point masses, sequencer around one shared unit
// load command: written straight into node memory, block stays ready
// step: spring pass, then node pass, then one result beat per node
// shared unit: 64-step divide, 32-step root, multiply per bit
// results come as strobed beats, receiver cannot stall
// reset: registers to defaults, per-node valid bits cleared at once, no clearing pass
module mass_spring_rope_step_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  msr_pkg::cmd_t                  cmd,
  output logic                           result_valid,
  output msr_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import msr_pkg::*;

  logic               mode;
  logic [6:0]         node_count;
  logic [15:0]        time_step;
  logic signed [31:0] gravity_x;
  logic signed [31:0] gravity_y;
  logic [30:0]        stiffness;
  logic [30:0]        pt_mass;
  logic [30:0]        spring_len;

  state_t             state;
  state_t             state_next;
  logic               issued;
  logic [IDX_W-1:0]   i;
  logic               axis;
  node_t              A;
  node_t              B;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] span;
  logic signed [31:0] ext;
  logic signed [63:0] t0;
  logic signed [63:0] q_x;
  logic signed [63:0] q_y;
  logic signed [31:0] acc;
  logic signed [63:0] h;
  logic signed [63:0] e;
  logic [MAX_NODES-1:0] valid;
  logic [IDX_W-1:0]   rd_addr_q;

  logic [CNT_W-1:0]   n_use;
  logic               i_last;
  logic               load_we;
  logic               seq_we;
  logic               use_alu;
  logic               alu_start;
  alu_req_t           req;
  alu_rsp_t           rsp;
  logic               adone;
  logic [IDX_W-1:0]   raddr;
  node_t              wnode;
  node_t              load_node;
  logic [$bits(node_t)-1:0] ram_rdata;
  node_t              rd_node;
  node_t              rd_m;
  logic signed [31:0] dsel;
  logic signed [63:0] qsel;
  logic signed [31:0] psel;
  logic signed [31:0] vsel;
  logic signed [31:0] ppsel;
  logic signed [31:0] fsel;
  logic signed [31:0] gsel;
  logic signed [63:0] num;
  logic signed [63:0] mass_eff;
  logic signed [63:0] c_x;
  logic signed [63:0] c_y;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
      node_count <= 7'd16;
      time_step <= 16'd1092;
      gravity_x <= '0;
      gravity_y <= '0;
      stiffness <= 31'd65536;
      pt_mass <= 31'd65536;
      spring_len <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MODE:   mode <= cfg_data[0];
        CFG_COUNT:  node_count <= cfg_data[6:0];
        CFG_TSTEP:  time_step <= cfg_data[15:0];
        CFG_GRAV_X: gravity_x <= cfg_data;
        CFG_GRAV_Y: gravity_y <= cfg_data;
        CFG_STIFF:  stiffness <= cfg_data[30:0];
        CFG_MASS:   pt_mass <= cfg_data[30:0];
        CFG_REST:   spring_len <= cfg_data[30:0];
      endcase
    end
  end

  always_comb begin
    if (node_count < 7'd2) n_use = CNT_W'(2);
    else if (CNT_W'(node_count) > CNT_W'(MAX_NODES)) n_use = CNT_W'(MAX_NODES);
    else n_use = CNT_W'(node_count);
  end

  assign i_last = CNT_W'(i) == n_use - CNT_W'(1);
  assign busy = state != ST_IDLE;
  assign load_we = start && !busy && cmd.operation == OP_LOAD;

  // node memory
  assign rd_node = node_t'(ram_rdata);
  assign rd_m = mask_node(rd_node, valid[rd_addr_q]);

  always_comb begin
    load_node = '{px: cmd.pos_x, py: cmd.pos_y, vx: '0, vy: '0,
                  qx: cmd.pos_x, qy: cmd.pos_y, fx: '0, fy: '0, pin: cmd.pinned};
    wnode = A;
    if (state == ND_WR && !mode) begin
      wnode.fx = '0;
      wnode.fy = '0;
    end
    if (load_we) wnode = load_node;
  end

  msr_ram #(
    .WIDTH($bits(node_t)),
    .DEPTH(MAX_NODES)
  ) u_ram (
    .clk  (clk),
    .we   (load_we || seq_we),
    .waddr(load_we ? IDX_W'(cmd.node_index) : i),
    .wdata(wnode),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (load_we) begin
      valid[IDX_W'(cmd.node_index)] <= 1'b1;
    end
    rd_addr_q <= raddr;
  end

  // shared unit
  assign adone = rsp.done;
  assign alu_start = use_alu && !issued;

  msr_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .start(alu_start),
    .req  (req),
    .rsp  (rsp)
  );

  always_comb begin
    dsel = axis ? dy : dx;
    qsel = axis ? q_y : q_x;
    psel = axis ? A.py : A.px;
    vsel = axis ? A.vy : A.vx;
    ppsel = axis ? A.qy : A.qx;
    fsel = axis ? A.fy : A.fx;
    gsel = axis ? gravity_y : gravity_x;
    num = mode ? 64'(fsel) : t0;
    mass_eff = (pt_mass == '0) ? 64'sd1 : 64'(pt_mass);
    c_x = (!A.pin && !B.pin) ? half(q_x) : q_x;
    c_y = (!A.pin && !B.pin) ? half(q_y) : q_y;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    use_alu = 1'b0;
    seq_we = 1'b0;
    raddr = i;
    req = '{op: ALU_MUL, a: '0, b: '0};
    unique case (state)
      ST_IDLE: if (start && cmd.operation == OP_STEP) state_next = SP_RD_A;
      SP_RD_A: begin
        raddr = '0;
        state_next = SP_LD_A;
      end
      SP_LD_A: state_next = SP_RD_B;
      SP_RD_B: begin
        raddr = i + IDX_W'(1);
        state_next = SP_LD_B;
      end
      SP_LD_B: state_next = (mode && A.pin && rd_m.pin) ? SP_WR : SP_GEO;
      SP_GEO: state_next = SP_SQ;
      SP_SQ: begin
        use_alu = 1'b1;
        req = '{op: ALU_MUL, a: 64'(dsel), b: 64'(dsel)};
        if (adone && axis) state_next = SP_ROOT;
      end
      SP_ROOT: begin
        use_alu = 1'b1;
        req = '{op: ALU_SQRT, a: t0, b: '0};
        if (adone) state_next = SP_EXT;
      end
      SP_EXT: state_next = (span == '0) ? SP_WR : SP_M;
      SP_M: begin
        use_alu = 1'b1;
        req = '{op: ALU_MUL, a: 64'(dsel), b: 64'(ext)};
        if (adone) state_next = SP_D;
      end
      SP_D: begin
        use_alu = 1'b1;
        req = '{op: ALU_DIV, a: t0, b: 64'(span)};
        if (adone) state_next = !axis ? SP_M : (mode ? SP_APPLY : SP_K);
      end
      SP_K: begin
        use_alu = 1'b1;
        req = '{op: ALU_MUL, a: 64'(stiffness), b: qsel};
        if (adone && axis) state_next = SP_APPLY;
      end
      SP_APPLY: state_next = SP_WR;
      SP_WR: begin
        seq_we = 1'b1;
        state_next = (CNT_W'(i) + CNT_W'(2) == n_use) ? SP_WR_LAST : SP_RD_B;
      end
      SP_WR_LAST: begin
        seq_we = 1'b1;
        state_next = ND_RD;
      end
      ND_RD: state_next = ND_LD;
      ND_LD: begin
        if (rd_m.pin) state_next = mode ? ND_NEXT : ND_WR;
        else state_next = mode ? ND_ACC : ND_DAMP;
      end
      ND_DAMP: begin
        use_alu = 1'b1;
        req = '{op: ALU_MUL, a: 64'(vsel), b: DAMP_EULER};
        if (adone) state_next = ND_ACC;
      end
      ND_ACC: begin
        use_alu = 1'b1;
        req = '{op: ALU_DIV, a: num <<< FRAC_BITS, b: mass_eff};
        if (adone) state_next = mode ? ND_H : ND_VEL;
      end
      ND_VEL: begin
        use_alu = 1'b1;
        req = '{op: ALU_MUL, a: 64'(acc), b: 64'(time_step)};
        if (adone) state_next = ND_POS;
      end
      ND_POS: begin
        use_alu = 1'b1;
        req = '{op: ALU_MUL, a: 64'(vsel), b: 64'(time_step)};
        if (adone) state_next = axis ? ND_WR : ND_DAMP;
      end
      ND_H: begin
        use_alu = 1'b1;
        req = '{op: ALU_MUL, a: 64'(acc), b: 64'(time_step)};
        if (adone) state_next = ND_G;
      end
      ND_G: begin
        use_alu = 1'b1;
        req = '{op: ALU_MUL, a: h, b: 64'(time_step)};
        if (adone) state_next = ND_E;
      end
      ND_E: begin
        use_alu = 1'b1;
        req = '{op: ALU_MUL, a: KEEP_VERLET, b: 64'(psel) - 64'(ppsel)};
        if (adone) state_next = ND_VUP;
      end
      ND_VUP: state_next = axis ? ND_WR : ND_ACC;
      ND_WR: begin
        seq_we = 1'b1;
        state_next = ND_NEXT;
      end
      ND_NEXT: state_next = i_last ? OT_RD : ND_RD;
      OT_RD: state_next = OT_EM;
      OT_EM: state_next = i_last ? ST_IDLE : OT_RD;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= 1'b0;
      i <= '0;
      axis <= 1'b0;
    end else begin
      if (alu_start) issued <= 1'b1;
      else if (adone) issued <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          i <= '0;
          axis <= 1'b0;
        end
        SP_LD_A: A <= rd_m;
        SP_LD_B: B <= rd_m;
        SP_GEO: begin
          dx <= sat32(64'(B.px) - 64'(A.px));
          dy <= sat32(64'(B.py) - 64'(A.py));
          axis <= 1'b0;
        end
        SP_SQ: if (adone) begin
          t0 <= axis ? t0 + rsp.res : rsp.res;
          axis <= !axis;
        end
        SP_ROOT: if (adone) span <= sat32(rsp.res);
        SP_EXT: ext <= sat32(64'(span) - 64'(spring_len));
        SP_M: if (adone) t0 <= rsp.res;
        SP_D: if (adone) begin
          if (axis) q_y <= rsp.res;
          else q_x <= rsp.res;
          axis <= !axis;
        end
        SP_K: if (adone) begin
          if (axis) q_y <= 64'(sat32(sdiv_one(rsp.res)));
          else q_x <= 64'(sat32(sdiv_one(rsp.res)));
          axis <= !axis;
        end
        SP_APPLY: begin
          if (!mode) begin
            A.fx <= sat32(64'(A.fx) + q_x);
            A.fy <= sat32(64'(A.fy) + q_y);
            B.fx <= sat32(64'(B.fx) - q_x);
            B.fy <= sat32(64'(B.fy) - q_y);
          end else begin
            if (!A.pin) begin
              A.px <= sat32(64'(A.px) + c_x);
              A.py <= sat32(64'(A.py) + c_y);
            end
            if (!B.pin) begin
              B.px <= sat32(64'(B.px) - c_x);
              B.py <= sat32(64'(B.py) - c_y);
            end
          end
        end
        SP_WR: begin
          A <= B;
          i <= i + IDX_W'(1);
        end
        SP_WR_LAST: i <= '0;
        ND_LD: begin
          A <= rd_m;
          axis <= 1'b0;
        end
        ND_DAMP: if (adone) t0 <= 64'(fsel) - sdiv_one(rsp.res);
        ND_ACC: if (adone) acc <= sat32(64'(sat32(rsp.res)) + 64'(gsel));
        ND_VEL: if (adone) begin
          if (axis) A.vy <= sat32(64'(vsel) + sdiv_one(rsp.res));
          else A.vx <= sat32(64'(vsel) + sdiv_one(rsp.res));
        end
        ND_POS: if (adone) begin
          if (axis) A.py <= sat32(64'(psel) + sdiv_one(rsp.res));
          else A.px <= sat32(64'(psel) + sdiv_one(rsp.res));
          axis <= !axis;
        end
        ND_H: if (adone) h <= sdiv_one(rsp.res);
        ND_G: if (adone) h <= sdiv_one(rsp.res);
        ND_E: if (adone) e <= sdiv_one(rsp.res);
        ND_VUP: begin
          if (axis) begin
            A.py <= sat32(64'(psel) + e + h);
            A.qy <= psel;
          end else begin
            A.px <= sat32(64'(psel) + e + h);
            A.qx <= psel;
          end
          axis <= !axis;
        end
        ND_NEXT: i <= i_last ? '0 : i + IDX_W'(1);
        OT_EM: i <= i + IDX_W'(1);
        default: ;
      endcase
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= state == OT_EM;
    end
    if (state == OT_EM) begin
      result <= '{out_index: 6'(i), out_x: rd_node.px, out_y: rd_node.py,
                  last_node: i_last};
    end
  end

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == OT_EM)
    else $error("result beat without an emit cycle");

  a_alu_free: assert property (@(posedge clk) disable iff (rst)
    alu_start |-> !rsp.busy)
    else $error("shared unit started while running");

  a_step_go: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.operation == OP_STEP) |=> state == SP_RD_A)
    else $error("accepted step did not start the spring pass");

  a_idx: assert property (@(posedge clk) disable iff (rst)
    busy |-> CNT_W'(i) < n_use)
    else $error("node index beyond nodes in use");

endmodule

[design/msr_ram.sv]
// generic single-write, single-read ram with registered read data
module msr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/msr_alu.sv]
// shared iterative unit: shift-add multiply, restoring divide, integer square root
module msr_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  msr_pkg::alu_req_t req,
  output msr_pkg::alu_rsp_t rsp
);
  import msr_pkg::*;

  localparam logic [6:0] DIV_STEPS = 7'd64;
  localparam logic [6:0] ROOT_STEPS = 7'd32;

  logic               run;
  logic               done;
  logic signed [63:0] res;
  alu_op_t            op_q;
  logic               neg;
  logic [6:0]         cnt;
  logic [63:0]        x;
  logic [63:0]        y;
  logic [64:0]        z;
  logic [63:0]        mag_a;
  logic [63:0]        mag_b;
  logic [64:0]        rem_sh;
  logic               rem_ge;
  logic [64:0]        rem_sub;
  logic [63:0]        sq_try;
  logic               sq_ge;

  always_comb begin
    mag_a = req.a[63] ? 64'(-req.a) : 64'(req.a);
    mag_b = req.b[63] ? 64'(-req.b) : 64'(req.b);
    rem_sh = {z[63:0], x[63]};
    rem_ge = rem_sh >= {1'b0, y};
    rem_sub = rem_sh - {1'b0, y};
    sq_try = z[63:0] + y;
    sq_ge = x >= sq_try;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !run) begin
        run <= 1'b1;
        op_q <= req.op;
        cnt <= '0;
        neg <= req.a[63] ^ req.b[63];
        z <= '0;
        if (req.op == ALU_SQRT) begin
          x <= 64'(req.a);
          y <= 64'h4000_0000_0000_0000;
        end else begin
          x <= mag_a;
          y <= mag_b;
        end
      end else if (run) begin
        unique case (op_q)
          ALU_MUL: begin
            if (y == '0) begin
              run <= 1'b0;
              done <= 1'b1;
              res <= neg ? -$signed(z[63:0]) : $signed(z[63:0]);
            end else begin
              if (y[0]) z <= {1'b0, z[63:0] + x};
              x <= x << 1;
              y <= y >> 1;
            end
          end
          ALU_DIV: begin
            if (cnt == DIV_STEPS) begin
              run <= 1'b0;
              done <= 1'b1;
              res <= neg ? -$signed(x) : $signed(x);
            end else begin
              z <= rem_ge ? rem_sub : rem_sh;
              x <= {x[62:0], rem_ge};
              cnt <= cnt + 7'd1;
            end
          end
          ALU_SQRT: begin
            if (cnt == ROOT_STEPS) begin
              run <= 1'b0;
              done <= 1'b1;
              res <= $signed(z[63:0]);
            end else begin
              if (sq_ge) begin
                x <= x - sq_try;
                z <= {1'b0, (z[63:0] >> 1) + y};
              end else begin
                z <= z >> 1;
              end
              y <= y >> 2;
              cnt <= cnt + 7'd1;
            end
          end
          default: run <= 1'b0;
        endcase
      end
    end
  end

  assign rsp = '{busy: run, done: done, res: res};

endmodule

[bench/testbench.sv]
// testbench: directed and random load/step traffic against a bit-exact rope predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msr_pkg::*;

  localparam longint Q_ONE = 65536;
  localparam longint EULER_DAMP = 328;
  localparam longint VERLET_DAMP = 3;
  localparam int QUIET_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic result_valid;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  mass_spring_rope_step_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  longint r_mode, r_count, r_tstep, r_gx, r_gy, r_stiff, r_mass, r_rest;
  int px[64], py[64], vx[64], vy[64], qx[64], qy[64], fx[64], fy[64];
  bit pin[64];
  bit loaded[64];
  result_t pos_q[$];
  int errors = 0;
  int idle_pct = 0;
  int quiet = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit spring_shape(int i, output longint dx, output longint dy,
                                      output longint span, output longint ext);
    longint unsigned sx, sy;
    dx = clamp32(longint'(px[i+1]) - longint'(px[i]));
    dy = clamp32(longint'(py[i+1]) - longint'(py[i]));
    sx = dx * dx;
    sy = dy * dy;
    span = clamp32(longint'(int_sqrt(sx + sy)));
    ext = 0;
    if (span == 0) return 1'b0;
    ext = clamp32(span - r_rest);
    return 1'b1;
  endfunction

  function automatic longint accel(longint num, longint g);
    longint m;
    m = (r_mass != 0) ? r_mass : 1;
    return clamp32(clamp32(num * Q_ONE / m) + g);
  endfunction

  task automatic euler_pass(int n);
    longint dx, dy, span, ext, sfx, sfy, ax, ay;
    for (int i = 0; i + 1 < n; i++) begin
      if (spring_shape(i, dx, dy, span, ext)) begin
        sfx = clamp32(r_stiff * (dx * ext / span) / Q_ONE);
        sfy = clamp32(r_stiff * (dy * ext / span) / Q_ONE);
        fx[i] = int'(clamp32(longint'(fx[i]) + sfx));
        fy[i] = int'(clamp32(longint'(fy[i]) + sfy));
        fx[i+1] = int'(clamp32(longint'(fx[i+1]) - sfx));
        fy[i+1] = int'(clamp32(longint'(fy[i+1]) - sfy));
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!pin[i]) begin
        ax = accel(longint'(fx[i]) - longint'(vx[i]) * EULER_DAMP / Q_ONE, r_gx);
        ay = accel(longint'(fy[i]) - longint'(vy[i]) * EULER_DAMP / Q_ONE, r_gy);
        vx[i] = int'(clamp32(longint'(vx[i]) + ax * r_tstep / Q_ONE));
        vy[i] = int'(clamp32(longint'(vy[i]) + ay * r_tstep / Q_ONE));
        px[i] = int'(clamp32(longint'(px[i]) + longint'(vx[i]) * r_tstep / Q_ONE));
        py[i] = int'(clamp32(longint'(py[i]) + longint'(vy[i]) * r_tstep / Q_ONE));
      end
      fx[i] = 0;
      fy[i] = 0;
    end
  endtask

  task automatic verlet_pass(int n);
    longint dx, dy, span, ext, cx, cy, ax, ay, ox, oy;
    for (int i = 0; i + 1 < n; i++) begin
      if (!(pin[i] && pin[i+1]) && spring_shape(i, dx, dy, span, ext)) begin
        cx = dx * ext / span;
        cy = dy * ext / span;
        if (!pin[i] && !pin[i+1]) begin
          cx = cx / 2;
          cy = cy / 2;
        end
        if (!pin[i]) begin
          px[i] = int'(clamp32(longint'(px[i]) + cx));
          py[i] = int'(clamp32(longint'(py[i]) + cy));
        end
        if (!pin[i+1]) begin
          px[i+1] = int'(clamp32(longint'(px[i+1]) - cx));
          py[i+1] = int'(clamp32(longint'(py[i+1]) - cy));
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!pin[i]) begin
        ax = accel(fx[i], r_gx);
        ay = accel(fy[i], r_gy);
        ox = px[i];
        oy = py[i];
        px[i] = int'(clamp32(ox + (Q_ONE - VERLET_DAMP) * (ox - qx[i]) / Q_ONE
                             + (ax * r_tstep / Q_ONE) * r_tstep / Q_ONE));
        py[i] = int'(clamp32(oy + (Q_ONE - VERLET_DAMP) * (oy - qy[i]) / Q_ONE
                             + (ay * r_tstep / Q_ONE) * r_tstep / Q_ONE));
        qx[i] = int'(ox);
        qy[i] = int'(oy);
      end
    end
  endtask

  function automatic int nodes_in_use();
    if (r_count < 2) return 2;
    if (r_count > 64) return 64;
    return int'(r_count);
  endfunction

  task automatic rope_update(cmd_t c);
    int n, k;
    result_t r;
    if (c.operation == OP_LOAD) begin
      k = c.node_index;
      px[k] = c.pos_x;
      py[k] = c.pos_y;
      qx[k] = c.pos_x;
      qy[k] = c.pos_y;
      vx[k] = 0;
      vy[k] = 0;
      fx[k] = 0;
      fy[k] = 0;
      pin[k] = c.pinned;
      loaded[k] = 1'b1;
    end else begin
      n = nodes_in_use();
      if (r_mode != 0) verlet_pass(n);
      else euler_pass(n);
      for (int i = 0; i < n; i++) begin
        r.out_index = i[5:0];
        r.out_x = px[i];
        r.out_y = py[i];
        r.last_node = (i == n - 1);
        pos_q.push_back(r);
      end
    end
  endtask

  task automatic send_item(op_t op, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                           logic p);
    cmd_t c;
    c.operation = op;
    c.node_index = idx;
    c.pos_x = x;
    c.pos_y = y;
    c.pinned = p;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    rope_update(c);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pos_q.size() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t reg_id, logic [31:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= reg_id;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (reg_id)
      CFG_MODE:   r_mode = d[0];
      CFG_COUNT:  r_count = d[6:0];
      CFG_TSTEP:  r_tstep = d[15:0];
      CFG_GRAV_X: r_gx = longint'(signed'(d));
      CFG_GRAV_Y: r_gy = longint'(signed'(d));
      CFG_STIFF:  r_stiff = d[30:0];
      CFG_MASS:   r_mass = d[30:0];
      CFG_REST:   r_rest = d[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic step();
    // never step over a node that was not loaded
    for (int i = 0; i < nodes_in_use(); i++)
      if (!loaded[i]) send_item(OP_LOAD, i[5:0], $urandom, $urandom, 1'b0);
    send_item(OP_STEP, 6'($urandom), $urandom, $urandom, 1'($urandom));
  endtask

  task automatic load_rand(int idx);
    send_item(OP_LOAD, idx[5:0], $urandom >> $urandom_range(0, 31),
              $urandom >> $urandom_range(0, 31), $urandom_range(9) < 2);
  endtask

  task automatic test_load_all();
    for (int i = 0; i < 64; i++) load_rand(i);
  endtask

  task automatic test_reset_defaults();
    step();
    step();
  endtask

  task automatic test_euler_extremes();
    cfg_write(CFG_MODE, 32'd0);
    cfg_write(CFG_COUNT, 32'd64);
    cfg_write(CFG_TSTEP, 32'hffff);
    cfg_write(CFG_GRAV_X, 32'h7fffffff);
    cfg_write(CFG_GRAV_Y, 32'h80000000);
    cfg_write(CFG_STIFF, 32'h7fffffff);
    cfg_write(CFG_MASS, 32'd0);
    cfg_write(CFG_REST, 32'd0);
    send_item(OP_LOAD, 6'd0, 32'h80000000, 32'h7fffffff, 1'b0);
    send_item(OP_LOAD, 6'd1, 32'h7fffffff, 32'h80000000, 1'b0);
    // coincident pair gives a zero-length spring
    send_item(OP_LOAD, 6'd2, 32'h00012345, 32'hfff00000, 1'b0);
    send_item(OP_LOAD, 6'd3, 32'h00012345, 32'hfff00000, 1'b1);
    send_item(OP_LOAD, 6'd63, 32'hffffffff, 32'h00000000, 1'b1);
    step();
    step();
  endtask

  task automatic test_count_saturation();
    cfg_write(CFG_COUNT, 32'd0);
    step();
    cfg_write(CFG_COUNT, 32'd1);
    step();
    cfg_write(CFG_MODE, 32'd1);
    cfg_write(CFG_COUNT, 32'd127);
    step();
  endtask

  task automatic test_verlet_pins();
    cfg_write(CFG_COUNT, 32'd4);
    cfg_write(CFG_TSTEP, 32'd0);
    cfg_write(CFG_GRAV_X, 32'd0);
    cfg_write(CFG_GRAV_Y, 32'hfffe0000);
    cfg_write(CFG_MASS, 32'h7fffffff);
    cfg_write(CFG_REST, 32'h7fffffff);
    send_item(OP_LOAD, 6'd0, 32'h00000000, 32'h00000000, 1'b1);
    send_item(OP_LOAD, 6'd1, 32'h00020000, 32'h00000000, 1'b1);
    send_item(OP_LOAD, 6'd2, 32'h00030000, 32'h00010000, 1'b0);
    send_item(OP_LOAD, 6'd3, 32'h00030000, 32'h00010000, 1'b0);
    step();
    cfg_write(CFG_TSTEP, 32'd1092);
    cfg_write(CFG_REST, 32'h00010000);
    step();
  endtask

  task automatic test_index_beyond_count();
    cfg_write(CFG_COUNT, 32'd3);
    send_item(OP_LOAD, 6'd5, 32'h00050000, 32'h00001000, 1'b0);
    step();
    cfg_write(CFG_COUNT, 32'd6);
    step();
  endtask

  task automatic test_random();
    int items;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 47;
        2: idle_pct = 29;
        default: idle_pct = 47;
      endcase
      cfg_write(CFG_MODE, $urandom_range(1));
      cfg_write(CFG_COUNT, (ph == 5) ? 64 : $urandom_range(2, 8));
      cfg_write(CFG_TSTEP, $urandom_range(65535));
      cfg_write(CFG_GRAV_X, $urandom >> $urandom_range(0, 31));
      cfg_write(CFG_GRAV_Y, $urandom >> $urandom_range(0, 31));
      cfg_write(CFG_STIFF, $urandom >> $urandom_range(0, 31));
      cfg_write(CFG_MASS, $urandom >> $urandom_range(0, 31));
      cfg_write(CFG_REST, $urandom >> $urandom_range(0, 31));
      items = (ph == 5) ? 6 : 10;
      for (int k = 0; k < items; k++) begin
        if ($urandom_range(99) < 45) load_rand($urandom_range(0, 63));
        else step();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pos_q.size() == 0) begin
        $display("%0t unexpected result beat: %p", $time, result);
        errors++;
      end else begin
        result_t e;
        e = pos_q.pop_front();
        if (result.out_index !== e.out_index) begin
          $display("%0t out_index exp %0d act %0d", $time, e.out_index, result.out_index);
          errors++;
        end
        if (result.out_x !== e.out_x) begin
          $display("%0t out_x exp %h act %h", $time, e.out_x, result.out_x);
          errors++;
        end
        if (result.out_y !== e.out_y) begin
          $display("%0t out_y exp %h act %h", $time, e.out_y, result.out_y);
          errors++;
        end
        if (result.last_node !== e.last_node) begin
          $display("%0t last_node exp %b act %b", $time, e.last_node, result.last_node);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    r_mode = 1;
    r_count = 16;
    r_tstep = 1092;
    r_gx = 0;
    r_gy = 0;
    r_stiff = 65536;
    r_mass = 65536;
    r_rest = 65536;
    for (int i = 0; i < 64; i++) begin
      px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0;
      qx[i] = 0; qy[i] = 0; fx[i] = 0; fy[i] = 0;
      pin[i] = 0; loaded[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_load_all();
    test_reset_defaults();
    test_euler_extremes();
    test_count_saturation();
    test_verlet_pins();
    test_index_beyond_count();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[files.f]
design/msr_pkg.sv
design/msr_ram.sv
design/msr_alu.sv
design/mass_spring_rope_step_unit.sv
bench/testbench.sv
